FILE: rtl/ssfb_pkg.sv
// Shared types, constants and look-up functions for the seven-segment frame builder.
// No dependencies; all other files of the block but ssfb_checker import it.
`default_nettype none

package ssfb_pkg;

  // Command codes carried on the input tuser.
  typedef enum logic [1:0] {
    FUNC_NUMBER = 2'd0,
    FUNC_DIGIT  = 2'd1,
    FUNC_INIT   = 2'd2
  } func_e;

  localparam int VALUE_W  = 14;
  localparam int POS_W    = 2;
  localparam int IDX_W    = 4;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 3;

  localparam logic [VALUE_W-1:0] NUMBER_MAX = VALUE_W'(9999);
  localparam logic [VALUE_W-1:0] DIGIT_MAX  = VALUE_W'(9);

  // Reciprocal of ten, scaled by 2^19, for the digit split.
  localparam logic [16:0] RECIP_TEN = 17'd52429;
  localparam int          RECIP_SHIFT = 19;

  localparam logic [7:0] BYTE_BLANK      = 8'h00;
  localparam logic [7:0] BYTE_AUTO_INC   = 8'h40;
  localparam logic [7:0] BYTE_FIXED_ADDR = 8'h44;
  localparam logic [7:0] BYTE_ADDR0      = 8'hc0;
  localparam logic [7:0] BYTE_CTRL       = 8'h80;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    func_e                kind;
    logic [VALUE_W-1:0]   value;
    logic [POS_W-1:0]     position;
  } cmd_t;

  typedef struct packed {
    logic [2:0] brightness;
    logic       display_enable;
  } cfg_t;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // Index of the final byte each command produces.
  function automatic logic [IDX_W-1:0] last_index(input func_e kind);
    logic [IDX_W-1:0] idx;
    case (kind)
      FUNC_NUMBER: idx = IDX_W'(10);
      FUNC_DIGIT:  idx = IDX_W'(3);
      default:     idx = IDX_W'(1);
    endcase
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssfb_front.sv
// Front end: accepts command items, drops the unused code and saturates the value.
// Depends on ssfb_pkg; feeds ssfb_queue.
`default_nettype none

module ssfb_front import ssfb_pkg::*; (
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [13:0] value, [15:14] position
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  input  wire logic        q_full,
  output logic             push,
  output cmd_t             push_data
);

  logic [VALUE_W-1:0] value;
  logic               known;

  assign value     = in_tdata[VALUE_W-1:0];
  assign in_tready = !q_full;

  always_comb begin
    push_data.kind     = func_e'(in_tuser);
    push_data.position = in_tdata[VALUE_W +: POS_W];
    push_data.value    = value;
    known              = 1'b1;
    case (in_tuser)
      FUNC_NUMBER: begin
        if (value > NUMBER_MAX) push_data.value = NUMBER_MAX;
      end
      FUNC_DIGIT: begin
        if (value > DIGIT_MAX) push_data.value = DIGIT_MAX;
      end
      FUNC_INIT: begin
        push_data.value = '0;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // The unused code is taken from the channel but produces nothing.
  assign push = in_tvalid && in_tready && known;

endmodule

`default_nettype wire

FILE: rtl/ssfb_queue.sv
// Short command queue between the front end and the byte sequencer.
// Depends on ssfb_pkg for the command type and depth.
`default_nettype none

module ssfb_queue import ssfb_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  cmd_t      push_data,
  output logic      full,
  input  wire logic pop,
  output logic      q_valid,
  output cmd_t      q_data
);

  cmd_t               mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] ptr);
    return (ptr == QPTR_W'(QDEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full    = (count_r == QCNT_W'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= bump(wr_ptr_r);
      if (pop)  rd_ptr_r <= bump(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssfb_back.sv
// Back end: walks a command's frame bytes to the output register, one byte
// per cycle when not stalled. Depends on ssfb_pkg; pops ssfb_queue.
`default_nettype none

module ssfb_back import ssfb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  cfg_t            cfg,
  input  wire logic       q_valid,
  input  cmd_t            q_data,
  output logic            pop,
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  logic               busy_r;
  cmd_t               cmd_r;
  logic [IDX_W-1:0]   idx_r;
  logic [VALUE_W-1:0] v_r;
  logic               ov_r;
  logic [7:0]         byte_r;
  logic               begin_r;
  logic               end_r;
  logic               last_r;

  logic               adv;
  logic               step;
  logic               is_last;
  logic               digit_step;
  logic [VALUE_W+16:0] prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] rem_full;
  logic [3:0]         rem;
  logic [7:0]         byte_nxt;
  logic               begin_nxt;
  logic               end_nxt;

  assign adv     = !ov_r || out_tready;
  assign step    = busy_r && adv;
  assign is_last = (idx_r == last_index(cmd_r.kind));
  assign pop     = q_valid && (!busy_r || (step && is_last));

  // Lowest decimal digit of the working value by reciprocal multiply.
  assign prod       = (VALUE_W+17)'(v_r) * (VALUE_W+17)'(RECIP_TEN);
  assign quot       = VALUE_W'(prod >> RECIP_SHIFT);
  assign rem_full   = v_r - (quot << 3) - (quot << 1);
  assign rem        = rem_full[3:0];
  assign digit_step = (cmd_r.kind == FUNC_NUMBER) && idx_r[0] && (idx_r >= IDX_W'(3));

  always_comb begin
    byte_nxt  = BYTE_BLANK;
    begin_nxt = 1'b0;
    end_nxt   = 1'b0;
    case (cmd_r.kind)
      FUNC_NUMBER: begin
        case (idx_r)
          IDX_W'(0): begin
            begin_nxt = 1'b1;
            end_nxt   = 1'b1;
          end
          IDX_W'(1): begin
            byte_nxt  = BYTE_AUTO_INC;
            begin_nxt = 1'b1;
            end_nxt   = 1'b1;
          end
          IDX_W'(2): begin
            byte_nxt  = BYTE_ADDR0;
            begin_nxt = 1'b1;
          end
          default: begin
            if (idx_r[0]) byte_nxt = seg_code(rem);
            end_nxt = is_last;
          end
        endcase
      end
      FUNC_DIGIT: begin
        case (idx_r)
          IDX_W'(0): begin
            begin_nxt = 1'b1;
            end_nxt   = 1'b1;
          end
          IDX_W'(1): begin
            byte_nxt  = BYTE_FIXED_ADDR;
            begin_nxt = 1'b1;
            end_nxt   = 1'b1;
          end
          IDX_W'(2): begin
            byte_nxt  = BYTE_ADDR0 | {5'd0, cmd_r.position, 1'b0};
            begin_nxt = 1'b1;
          end
          default: begin
            byte_nxt = seg_code(cmd_r.value[3:0]);
            end_nxt  = 1'b1;
          end
        endcase
      end
      default: begin
        begin_nxt = 1'b1;
        end_nxt   = 1'b1;
        if (idx_r != '0) begin
          byte_nxt = BYTE_CTRL | {4'd0, cfg.display_enable, cfg.brightness};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (adv) ov_r <= step;
      if (step) begin
        byte_r  <= byte_nxt;
        begin_r <= begin_nxt;
        end_r   <= end_nxt;
        last_r  <= is_last;
        idx_r   <= idx_r + 1'b1;
        if (digit_step) v_r <= quot;
        if (is_last) busy_r <= 1'b0;
      end
      if (pop) begin
        cmd_r  <= q_data;
        v_r    <= q_data.value;
        idx_r  <= '0;
        busy_r <= 1'b1;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = byte_r;
  assign out_tuser  = {end_r, begin_r};
  assign out_tlast  = last_r;

endmodule

`default_nettype wire

FILE: rtl/seven_segment_frame_builder.sv
// Top level of the seven-segment frame builder: configuration registers,
// front end, command queue and byte sequencer. Depends on ssfb_pkg and its sub-modules.
//
//   Channel  Direction  Handshake          Payload
//   in_      slave      in_tvalid/tready   tdata {position, value}, tuser func
//   out_     master     out_tvalid/tready  tdata frame byte, tuser {end, begin}, tlast
//   cfg_     slave      cfg_valid/ready    cfg_index, cfg_data
//
// A whole-number command produces eleven bytes, a single-digit command four and
// an init command two; the sequencer emits one byte per cycle while the output is
// not stalled. The two-entry queue lets new requests be taken while the sequencer
// is still busy, and a waiting command is loaded on the same edge that registers
// the previous one's last byte.
// Reset is synchronous and active low; it empties the queue and the output
// register and returns brightness to 7 and the display enable to 1.
// A stall on the output holds the registered byte; the input stalls only when the queue is full.
`default_nettype none

module seven_segment_frame_builder import ssfb_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [15:0]           in_tdata,   // [13:0] value, [15:14] position
  input  wire logic [1:0]            in_tuser,   // [1:0] func
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [7:0]                 out_tdata,  // [7:0] frame_byte
  output logic [1:0]                 out_tuser,  // [0] frame_begin, [1] frame_end
  output logic                       out_tlast,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_ENABLE = CFG_IDX_W'(1);

  cfg_t cfg_r;
  logic q_full;
  logic push;
  cmd_t push_data;
  logic pop;
  logic q_valid;
  cmd_t q_data;

  // Registers are always writable; an index beyond the list is ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness     <= 3'd7;
      cfg_r.display_enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BRIGHTNESS:     cfg_r.brightness     <= cfg_data[2:0];
        REG_DISPLAY_ENABLE: cfg_r.display_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ssfb_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ssfb_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  ssfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/ssfb_checker.sv
// Port-level checks on the frame builder's output stream, bound to the top level.
// Depends on seven_segment_frame_builder's port names only.
`default_nettype none

module ssfb_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [1:0] out_tuser,
  input wire logic       out_tlast
);

  logic expect_begin_r;

  // After a byte that closes a frame, the next byte must open one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_begin_r <= 1'b1;
    end else if (out_tvalid && out_tready) begin
      expect_begin_r <= out_tuser[1];
    end
  end

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output valid dropped while stalled");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1])
    else $error("last byte of a command does not end a frame");

  a_begin_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && expect_begin_r |-> out_tuser[0])
    else $error("byte after a frame end does not begin a frame");

endmodule

bind seven_segment_frame_builder ssfb_checker u_ssfb_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_seven_segment_frame_builder.sv
// Self-checking testbench for seven_segment_frame_builder: commands go in on the
// input stream, register settings on the config channel, frame bytes are checked on output.
// Depends on ssfb_pkg and the RTL of the block; nothing else is read.
`default_nettype none

module tb_seven_segment_frame_builder;
  timeunit 1ns;
  timeprecision 1ps;
  import ssfb_pkg::*;

  // The one function code that the block drops without producing any byte.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Configuration register indexes; anything above the display enable is unmapped.
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_EN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP        = 8'hff;

  // Driver protocol bytes.
  localparam logic [7:0] BLANK_BYTE      = 8'h00;
  localparam logic [7:0] AUTO_INC_BYTE   = 8'h40;
  localparam logic [7:0] FIXED_ADDR_BYTE = 8'h44;
  localparam logic [7:0] ADDR_BASE       = 8'hc0;
  localparam logic [7:0] CTRL_BASE       = 8'h80;

  localparam logic [7:0] SEGMENTS [10] = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                                           8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};

  // Idle time after the last expected byte, so that any stray byte would show up.
  localparam int QUIET_CYCLES  = 40;
  localparam int ITEMS_PER_RUN = 30;

  typedef struct packed {
    logic [7:0] code;
    logic       strobe_fall;
    logic       strobe_rise;
    logic       cmd_last;
  } frame_byte_t;

  // Keeps its own copy of the two registers, expands every accepted command request
  // into the bytes the display driver should receive, and compares the output with them.
  class frame_byte_tracker;
    frame_byte_t pending_bytes[$];
    logic [2:0]  brightness;
    logic        display_en;
    int          errors;
    int          commands;
    int          bytes_checked;
    int          config_writes;

    function new();
      brightness = 3'd7;
      display_en = 1'b1;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_BRIGHTNESS) begin
        brightness = data;
      end else if (idx == REG_DISPLAY_EN) begin
        display_en = data[0];
      end
      config_writes++;
    endfunction

    function void push(logic [7:0] code, logic fall, logic rise, logic tail);
      frame_byte_t b;
      b.code        = code;
      b.strobe_fall = fall;
      b.strobe_rise = rise;
      b.cmd_last    = tail;
      pending_bytes.push_back(b);
    endfunction

    function void expect_frames(logic [1:0] func, logic [VALUE_W-1:0] value,
                                logic [POS_W-1:0] position);
      int unsigned num;
      int          i;
      case (func)
        FUNC_NUMBER: begin
          // Saturate, then send the digits lowest first, each with a blank after it.
          num = (value > 14'd9999) ? 9999 : int'(value);
          push(BLANK_BYTE, 1'b1, 1'b1, 1'b0);
          push(AUTO_INC_BYTE, 1'b1, 1'b1, 1'b0);
          push(ADDR_BASE, 1'b1, 1'b0, 1'b0);
          for (i = 0; i < 4; i++) begin
            push(SEGMENTS[num % 10], 1'b0, 1'b0, 1'b0);
            push(BLANK_BYTE, 1'b0, i == 3, i == 3);
            num = num / 10;
          end
          commands++;
        end
        FUNC_DIGIT: begin
          num = (value > 14'd9) ? 9 : int'(value);
          push(BLANK_BYTE, 1'b1, 1'b1, 1'b0);
          push(FIXED_ADDR_BYTE, 1'b1, 1'b1, 1'b0);
          push(ADDR_BASE + {5'd0, position, 1'b0}, 1'b1, 1'b0, 1'b0);
          push(SEGMENTS[num], 1'b0, 1'b1, 1'b1);
          commands++;
        end
        FUNC_INIT: begin
          push(BLANK_BYTE, 1'b1, 1'b1, 1'b0);
          push(CTRL_BASE | {4'd0, display_en, brightness}, 1'b1, 1'b1, 1'b1);
          commands++;
        end
        default: begin
          // The unused code is swallowed silently.
        end
      endcase
    endfunction

    function void check_byte(frame_byte_t seen);
      frame_byte_t want;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        $display("%0t ns: unexpected byte, expected none, actual code %h fall %b rise %b last %b",
                 $time, seen.code, seen.strobe_fall, seen.strobe_rise, seen.cmd_last);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (seen !== want) begin
        // Fields are printed as code, strobe fall, strobe rise and command last.
        $display("%0t ns: byte mismatch, expected %h %b %b %b, actual %h %b %b %b",
                 $time, want.code, want.strobe_fall, want.strobe_rise, want.cmd_last,
                 seen.code, seen.strobe_fall, seen.strobe_rise, seen.cmd_last);
        errors++;
      end
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;  // [13:0] value, [15:14] position
  logic [1:0]            in_tuser   = '0;  // [1:0] func
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;        // [7:0] frame_byte
  logic [1:0]            out_tuser;        // [0] frame_begin, [1] frame_end
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Random gaps on the sender and stalls on the receiver; both are switched off
  // for the final stretch so that the block also runs back to back at full rate.
  bit idle_enable  = 1'b1;
  bit stall_enable = 1'b1;
  int stall_left   = 0;

  frame_byte_tracker tracker;

  seven_segment_frame_builder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // The receiver stalls in random bursts, changing only on the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if (stall_enable && $urandom_range(0, 5) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(1, 3) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  // Every accepted command request is expanded into its expected bytes at the very
  // edge on which it is taken, so the register copy matches what the block saw.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      tracker.expect_frames(in_tuser, in_tdata[13:0], in_tdata[15:14]);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      tracker.check_byte({out_tdata, out_tuser[0], out_tuser[1], out_tlast});
    end
  end

  // Presents one command request and holds it until the block takes it. Valid is
  // left high afterwards so that the next request can follow without a gap.
  task automatic send_command(input logic [1:0] func, input logic [VALUE_W-1:0] value,
                              input logic [POS_W-1:0] position);
    int gap;
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = {position, value};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops sending and waits until every expected byte is out, then leaves the
  // block idle for a while so that any stray byte would show up.
  task automatic settle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed commands with values in range, some saturating or
  // full-width values, and now and then the unused code, which does not count.
  task automatic run_random(input int count);
    int          sent;
    int          pick;
    logic [1:0]  func;
    logic [13:0] value;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        func = FUNC_UNUSED;
      end else if (pick < 50) begin
        func = FUNC_NUMBER;
      end else if (pick < 80) begin
        func = FUNC_DIGIT;
      end else begin
        func = FUNC_INIT;
      end
      pick = $urandom_range(0, 9);
      if (func == FUNC_NUMBER && pick < 7) begin
        value = 14'($urandom_range(0, 9999));
      end else if (func == FUNC_DIGIT && pick < 7) begin
        value = 14'($urandom_range(0, 9));
      end else begin
        value = 14'($urandom_range(0, 16383));
      end
      send_command(func, value, 2'($urandom_range(0, 3)));
      if (func != FUNC_UNUSED) sent++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part with the reset settings: zero, the largest number, values that
    // saturate, numbers that between them use every digit, single digits at every
    // position including saturating ones, two inits and the unused code twice.
    send_command(FUNC_NUMBER, 14'd0, 2'd0);
    send_command(FUNC_NUMBER, 14'd9999, 2'd3);
    send_command(FUNC_NUMBER, 14'd10000, 2'd0);
    send_command(FUNC_NUMBER, 14'd16383, 2'd3);
    send_command(FUNC_NUMBER, 14'd1234, 2'd1);
    send_command(FUNC_NUMBER, 14'd5678, 2'd2);
    send_command(FUNC_NUMBER, 14'd9090, 2'd0);
    send_command(FUNC_DIGIT, 14'd0, 2'd0);
    send_command(FUNC_DIGIT, 14'd9, 2'd1);
    send_command(FUNC_DIGIT, 14'd10, 2'd2);
    send_command(FUNC_DIGIT, 14'd16383, 2'd3);
    send_command(FUNC_DIGIT, 14'd4, 2'd0);
    send_command(FUNC_INIT, 14'd0, 2'd0);
    send_command(FUNC_UNUSED, 14'd16383, 2'd3);
    send_command(FUNC_UNUSED, 14'd0, 2'd0);
    send_command(FUNC_INIT, 14'd16383, 2'd3);
    settle();

    // Lowest brightness with the display switched off, the unused data bits set.
    write_register(REG_BRIGHTNESS, 3'd0);
    write_register(REG_DISPLAY_EN, 3'b110);
    send_command(FUNC_INIT, 14'd0, 2'd0);
    run_random(ITEMS_PER_RUN);
    settle();

    // Back to full brightness and on; then writes to unmapped indexes must change nothing.
    write_register(REG_BRIGHTNESS, 3'd7);
    write_register(REG_DISPLAY_EN, 3'b001);
    write_register(REG_SPARE, 3'd0);
    write_register(REG_TOP, 3'd5);
    send_command(FUNC_INIT, 14'd0, 2'd0);
    run_random(ITEMS_PER_RUN);
    settle();

    repeat (3) begin
      write_register(REG_BRIGHTNESS, 3'($urandom_range(0, 7)));
      write_register(REG_DISPLAY_EN, 3'($urandom_range(0, 7)));
      run_random(ITEMS_PER_RUN);
      settle();
    end

    // Final stretch at full rate: no gaps from the sender, no stalls from the receiver.
    idle_enable  = 1'b0;
    stall_enable = 1'b0;
    write_register(REG_BRIGHTNESS, 3'($urandom_range(0, 7)));
    write_register(REG_DISPLAY_EN, 3'($urandom_range(0, 7)));
    run_random(ITEMS_PER_RUN);
    settle();

    $display("Covered %0d commands (numbers, single digits and inits) giving %0d frame bytes,",
             tracker.commands, tracker.bytes_checked);
    $display("with %0d register writes including unmapped indexes and both stall regimes.",
             tracker.config_writes);
    if (tracker.errors == 0) begin
      $display("tb_seven_segment_frame_builder passed");
    end else begin
      $display("tb_seven_segment_frame_builder failed");
    end
    $finish;
  end

  // Guard against a hung handshake; the full run needs well under a tenth of this.
  initial begin
    #5_000_000;
    $display("Timeout with %0d bytes still expected", tracker.pending());
    $display("tb_seven_segment_frame_builder failed");
    $finish;
  end

endmodule

`default_nettype wire
